FILE: hdl/sapq_pkg.sv
package sapq_pkg;

  // Sizing
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned ITEM_BITS = 32;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PRIO_W  = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FREE_W  = 5;

  // Derived widths
  localparam int unsigned SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned TREE_N  = 1 << SLOT_W;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned STORE_W = (ITEM_BITS < WORD_W) ? ITEM_BITS : WORD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // run the request, update slots, load result
  } dp_cmd_t;

endpackage

FILE: hdl/sapq_ctrl.sv
module sapq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sapq_pkg::dp_cmd_t dp_cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;
  logic   exec;

  assign in_stall_o = (state_q == ST_EXEC);
  assign in_acc     = in_valid_i && !in_stall_o;
  // result register can take a new value when empty or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec       = (state_q == ST_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign dp_cmd_o.capture = in_acc;
  assign dp_cmd_o.execute = exec;

endmodule

FILE: hdl/sapq_dp.sv
module sapq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sapq_pkg::dp_cmd_t             dp_cmd_i,
  input  logic [sapq_pkg::CMD_W-1:0]    command_i,
  input  logic [sapq_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic [sapq_pkg::WORD_W-1:0]   content_i,
  output logic                          status_o,
  output logic [sapq_pkg::WORD_W-1:0]   item_out_o,
  output logic [sapq_pkg::FREE_W-1:0]   free_slots_o
);

  // Latched request
  sapq_pkg::cmd_e                     cmd_q;
  logic [sapq_pkg::PRIO_W-1:0]        prio_q;
  logic [sapq_pkg::STORE_W-1:0]       word_q;

  // Slot state
  logic [sapq_pkg::CAPACITY-1:0]      valid_q, valid_d;
  logic [sapq_pkg::PRIO_W-1:0]        prio_mem_q [sapq_pkg::CAPACITY];
  logic [sapq_pkg::STORE_W-1:0]       content_mem_q [sapq_pkg::CAPACITY];
  logic [sapq_pkg::CNT_W-1:0]         occ_q, occ_d;

  // Result register
  logic                               status_q, status_d;
  logic [sapq_pkg::WORD_W-1:0]        item_q, item_d;

  // Selection trees, node 1 is the root, leaves at TREE_N + slot
  logic                               bv   [2*sapq_pkg::TREE_N];
  logic [sapq_pkg::PRIO_W-1:0]        bp   [2*sapq_pkg::TREE_N];
  logic [sapq_pkg::SLOT_W-1:0]        bi   [2*sapq_pkg::TREE_N];
  logic                               fv   [2*sapq_pkg::TREE_N];
  logic [sapq_pkg::SLOT_W-1:0]        fi   [2*sapq_pkg::TREE_N];

  logic                               full;
  logic                               wr_en;

  // Highest priority, lower index wins ties (left child is lower); the free tree picks the lowest free slot
  always_comb begin
    for (int s = 0; s < sapq_pkg::TREE_N; s++) begin
      if (s < sapq_pkg::CAPACITY) begin
        bv[sapq_pkg::TREE_N+s] = valid_q[s];
        bp[sapq_pkg::TREE_N+s] = prio_mem_q[s];
        fv[sapq_pkg::TREE_N+s] = !valid_q[s];
      end else begin
        bv[sapq_pkg::TREE_N+s] = 1'b0;
        bp[sapq_pkg::TREE_N+s] = '0;
        fv[sapq_pkg::TREE_N+s] = 1'b0;
      end
      bi[sapq_pkg::TREE_N+s] = sapq_pkg::SLOT_W'(s);
      fi[sapq_pkg::TREE_N+s] = sapq_pkg::SLOT_W'(s);
    end
    bv[0] = 1'b0;
    bp[0] = '0;
    bi[0] = '0;
    fv[0] = 1'b0;
    fi[0] = '0;
    for (int n = sapq_pkg::TREE_N - 1; n >= 1; n--) begin
      if (bv[2*n] && (!bv[2*n+1] || bp[2*n] >= bp[2*n+1])) begin
        bv[n] = bv[2*n];
        bp[n] = bp[2*n];
        bi[n] = bi[2*n];
      end else begin
        bv[n] = bv[2*n+1];
        bp[n] = bp[2*n+1];
        bi[n] = bi[2*n+1];
      end
      if (fv[2*n]) begin
        fv[n] = 1'b1;
        fi[n] = fi[2*n];
      end else begin
        fv[n] = fv[2*n+1];
        fi[n] = fi[2*n+1];
      end
    end
  end

  assign full = (occ_q == sapq_pkg::CNT_W'(sapq_pkg::CAPACITY));

  always_comb begin
    valid_d  = valid_q;
    occ_d    = occ_q;
    status_d = 1'b0;
    item_d   = '0;
    wr_en    = 1'b0;
    case (cmd_q)
      sapq_pkg::CMD_ENQUEUE: begin
        if (full || !fv[1]) begin
          status_d = 1'b1;
        end else begin
          wr_en          = 1'b1;
          valid_d[fi[1]] = 1'b1;
          occ_d          = occ_q + sapq_pkg::CNT_W'(1);
        end
      end
      sapq_pkg::CMD_DEQUEUE,
      sapq_pkg::CMD_PEEK: begin
        if (!bv[1]) begin
          status_d = 1'b1;
        end else begin
          item_d = sapq_pkg::WORD_W'(content_mem_q[bi[1]]);
          // dequeue only frees the valid bit; stale priority is ignored
          if (cmd_q == sapq_pkg::CMD_DEQUEUE) begin
            valid_d[bi[1]] = 1'b0;
            occ_d          = occ_q - sapq_pkg::CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (dp_cmd_i.execute) begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q  <= sapq_pkg::cmd_e'(command_i);
      prio_q <= priority_req_i;
      word_q <= content_i[sapq_pkg::STORE_W-1:0];
    end
    if (dp_cmd_i.execute) begin
      status_q <= status_d;
      item_q   <= item_d;
      if (wr_en) begin
        prio_mem_q[fi[1]]    <= prio_q;
        content_mem_q[fi[1]] <= word_q;
      end
    end
  end

  assign status_o     = status_q;
  assign item_out_o   = item_q;
  assign free_slots_o = sapq_pkg::FREE_W'(sapq_pkg::CAPACITY) - sapq_pkg::FREE_W'(occ_q);

endmodule

FILE: hdl/slot_array_priority_queue.sv
// Channel  | Valid       | Stall        | Payload
// ---------+-------------+--------------+--------------------------------------
// request  | in_valid_i  | in_stall_o   | command_i, priority_req_i, content_i
// result   | out_valid_o | out_stall_i  | status_o, item_out_o, free_slots_o
//
// Each request is first latched, then in the execute state runs the slot
// selection trees (best priority and first free slot) and updates the slots.
// One request is in flight at a time; a new one is taken while the previous
// result still waits in the output register.
// The execute cycle holds off while a result is stalled on the output.
// Reset empties all slots at once through per-slot valid bits.
module slot_array_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sapq_pkg::CMD_W-1:0]  command_i,
  input  logic [sapq_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [sapq_pkg::WORD_W-1:0] content_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [sapq_pkg::WORD_W-1:0] item_out_o,
  output logic [sapq_pkg::FREE_W-1:0] free_slots_o
);

  // capture / execute strobes from the controller
  sapq_pkg::dp_cmd_t dp_cmd;

  // Controller: idle/execute sequencing and the result valid flag
  sapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd)
  );

  // Datapath: slot arrays, selection trees, occupancy count, result register
  sapq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .command_i      (command_i),
    .priority_req_i (priority_req_i),
    .content_i      (content_i),
    .status_o       (status_o),
    .item_out_o     (item_out_o),
    .free_slots_o   (free_slots_o)
  );

endmodule
